FILE: hdl/ppt_pkg.sv
`default_nettype none

package ppt_pkg;

    // Defaults for the top-level parameters.
    localparam int DEF_MAX_POINTS = 4096;
    localparam int DEF_WINDOW     = 16;

    // Field widths.
    localparam int OP_W       = 2;
    localparam int SEG_W      = 12;
    localparam int COORD_W    = 24;
    localparam int ARC_W      = 32;
    localparam int FRAC_W     = 17;
    localparam int LAP_W      = 16;
    localparam int DELTA_W    = 18;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // Internal datapath widths.
    localparam int DIFF_W  = COORD_W + 1;   // coordinate difference
    localparam int PT_W    = COORD_W + 2;   // offset to the closest point
    localparam int WIDE_W  = 52;            // squared lengths, dot products
    localparam int MA_W    = ARC_W + 2;     // multiplier operand A
    localparam int MB_W    = PT_W;          // multiplier operand B
    localparam int PROD_W  = MA_W + MB_W;
    localparam int QUOT_W  = DELTA_W;       // quotient bits of the divider
    localparam int STEP_W  = 5;             // divider step count
    localparam int IDX_W   = SEG_W + 2;     // signed candidate index
    localparam int NUM_W   = ARC_W + 3;     // signed progress numerator
    localparam int FRAC_Q  = 16;            // fraction bits

    localparam logic [FRAC_W-1:0] FRAC_ONE = 17'h10000;
    localparam logic signed [DELTA_W-1:0] DELTA_MAX = 18'sh1FFFF;
    localparam logic signed [DELTA_W-1:0] DELTA_MIN = 18'sh20000;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_LOAD    = 2'd0;
    localparam logic [OP_W-1:0] OP_PROJECT = 2'd1;
    localparam logic [OP_W-1:0] OP_RESTART = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_CLOSED = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEGCNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL  = 2'd2;

    // Request to the shared divider.
    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
    } t_div_req;

endpackage

`default_nettype wire

FILE: hdl/polyline_projection_tracker_unit.sv
`default_nettype none

// Channel    Direction  Handshake             Contents
// command    in         start / busy          operation, entry_index, pos_x, pos_y, entry_arc
// result     out        o_done strobe         progress_delta, lap_count, segment_now,
//                                             segment_fraction, arc_position
// config     in         i_cfg_we              i_cfg_idx, i_cfg_data
//
// A load, a restart or an unused code leaves the unit idle: its word is registered
// at acceptance and appears in the cycle after it, and the next command may be
// accepted in that same cycle. A projection visits 2*WINDOW+1 candidates through
// one shared multiplier and one shared bit-serial divider; a skipped candidate
// needs no arithmetic, and a tested one uses the divider only when its fraction
// lies strictly inside the segment. The arc and progress step follows the search.
// Reset is synchronous and needs no clearing pass; the point store is undefined
// until loaded. The result word is held for exactly one cycle; it cannot be stalled.
module polyline_projection_tracker_unit #(
    parameter int MAX_POINTS = ppt_pkg::DEF_MAX_POINTS,
    parameter int WINDOW     = ppt_pkg::DEF_WINDOW
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 start,
    output logic                                      busy,
    input  wire logic [ppt_pkg::OP_W-1:0]             i_operation,
    input  wire logic [ppt_pkg::SEG_W-1:0]            i_entry_index,
    input  wire logic signed [ppt_pkg::COORD_W-1:0]   i_pos_x,
    input  wire logic signed [ppt_pkg::COORD_W-1:0]   i_pos_y,
    input  wire logic [ppt_pkg::ARC_W-1:0]            i_entry_arc,
    input  wire logic                                 i_cfg_we,
    input  wire logic [ppt_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  wire logic [ppt_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    output logic                                      o_done,
    output logic signed [ppt_pkg::DELTA_W-1:0]        o_progress_delta,
    output logic signed [ppt_pkg::LAP_W-1:0]          o_lap_count,
    output logic [ppt_pkg::SEG_W-1:0]                 o_segment_now,
    output logic [ppt_pkg::FRAC_W-1:0]                o_segment_fraction,
    output logic [ppt_pkg::ARC_W-1:0]                 o_arc_position
);
    import ppt_pkg::*;

    localparam int AW     = $clog2(MAX_POINTS);
    localparam int CAND_N = 2 * WINDOW + 1;
    localparam int CW     = $clog2(CAND_N + 1);
    localparam int MEM_W  = 2 * COORD_W + ARC_W;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_CAND = 4'd1;
    localparam logic [3:0] S_RDA  = 4'd2;
    localparam logic [3:0] S_RDB  = 4'd3;
    localparam logic [3:0] S_MUL  = 4'd4;
    localparam logic [3:0] S_FRC  = 4'd5;
    localparam logic [3:0] S_DIV  = 4'd6;
    localparam logic [3:0] S_PT   = 4'd7;
    localparam logic [3:0] S_CMP  = 4'd8;
    localparam logic [3:0] S_FIN  = 4'd9;
    localparam logic [3:0] S_ARA  = 4'd10;
    localparam logic [3:0] S_ARB  = 4'd11;
    localparam logic [3:0] S_ARM  = 4'd12;
    localparam logic [3:0] S_PRG  = 4'd13;
    localparam logic [3:0] S_PDIV = 4'd14;
    localparam logic [3:0] S_OUT  = 4'd15;

    // Point store: x, y and arc in one word.
    logic [MEM_W-1:0]                mem [MAX_POINTS];
    logic [MEM_W-1:0]                r_rdata;
    logic [AW-1:0]                   rd_addr;
    logic signed [COORD_W-1:0]       rd_x;
    logic signed [COORD_W-1:0]       rd_y;
    logic [ARC_W-1:0]                rd_arc;

    // Sequencer and configuration.
    logic [3:0]                      r_state;
    logic [3:0]                      n_state;
    logic [2:0]                      r_step;
    logic [CW-1:0]                   r_cand;
    logic                            r_closed;
    logic [SEG_W-1:0]                r_segcnt;
    logic [ARC_W-1:0]                r_total;
    logic                            r_done;
    logic                            accept;

    // Tracked state.
    logic [SEG_W-1:0]                r_trk_seg;
    logic [FRAC_W-1:0]               r_trk_frac;
    logic signed [LAP_W-1:0]         r_trk_lap;
    logic [ARC_W-1:0]                r_trk_arc;

    // Per-candidate working registers.
    logic signed [COORD_W-1:0]       r_px;
    logic signed [COORD_W-1:0]       r_py;
    logic signed [COORD_W-1:0]       r_ax;
    logic signed [COORD_W-1:0]       r_ay;
    logic signed [DIFF_W-1:0]        r_abx;
    logic signed [DIFF_W-1:0]        r_aby;
    logic [WIDE_W-1:0]               r_len2;
    logic signed [WIDE_W-1:0]        r_dot;
    logic [FRAC_W-1:0]               r_t;
    logic signed [PT_W-1:0]          r_cx;
    logic signed [PT_W-1:0]          r_cy;
    logic [WIDE_W-1:0]               r_d2;
    logic [SEG_W-1:0]                r_seg_cur;
    logic signed [1:0]               r_ld_cur;

    // Best candidate so far.
    logic                            r_found;
    logic [WIDE_W-1:0]               r_best_d2;
    logic [SEG_W-1:0]                r_best_seg;
    logic [FRAC_W-1:0]               r_best_t;
    logic signed [1:0]               r_best_ld;

    // Arc and progress.
    logic [ARC_W-1:0]                r_a0;
    logic [ARC_W-1:0]                r_arc_new;
    logic signed [NUM_W-1:0]         r_num;
    logic signed [DELTA_W-1:0]       r_delta;

    // Output word.
    logic signed [DELTA_W-1:0]       r_o_delta;
    logic signed [LAP_W-1:0]         r_o_lap;
    logic [SEG_W-1:0]                r_o_seg;
    logic [FRAC_W-1:0]               r_o_frac;
    logic [ARC_W-1:0]                r_o_arc;

    // Candidate index logic.
    logic [CW:0]                     c_ext;
    logic [CW:0]                     off_mag;
    logic signed [CW+1:0]            c_off;
    logic signed [IDX_W-1:0]         idx_raw;
    logic signed [IDX_W-1:0]         idx_adj;
    logic signed [IDX_W-1:0]         seg_n;
    logic signed [1:0]               cand_ld;
    logic                            cand_ok;

    // Shared multiplier.
    logic signed [MA_W-1:0]          mul_a;
    logic signed [MB_W-1:0]          mul_b;
    logic signed [PROD_W-1:0]        r_prod;
    logic signed [PROD_W-1:0]        prod_rnd;
    logic signed [DIFF_W-1:0]        dx0;
    logic signed [DIFF_W-1:0]        dy0;
    logic signed [PT_W-1:0]          near_off;
    logic signed [PT_W-1:0]          near_c;
    logic signed [MB_W-1:0]          t_op;

    // Arc and progress arithmetic.
    logic signed [ARC_W+1:0]         arc_sum;
    logic signed [NUM_W-1:0]         ld_term;
    logic signed [NUM_W-1:0]         num_calc;
    logic [NUM_W-1:0]                num_mag;
    logic                            num_sat;

    // Shared divider.
    t_div_req                        div_req;
    logic [WIDE_W-1:0]               div_rem;
    logic [WIDE_W-1:0]               div_div;
    logic [QUOT_W-1:0]               div_feed;
    logic                            div_done;
    logic [QUOT_W-1:0]               div_quot;
    logic                            frc_div;
    logic                            prg_div;

    assign accept = start && (r_state == S_IDLE);
    assign busy   = (r_state != S_IDLE);

    // Candidate offset follows the order current, +1, -1, +2, -2 and so on.
    always_comb begin
        c_ext   = {1'b0, r_cand};
        off_mag = r_cand[0] ? ((c_ext + (CW+1)'(1)) >> 1) : (c_ext >> 1);
        c_off   = r_cand[0] ? $signed({1'b0, off_mag}) : -$signed({1'b0, off_mag});
        seg_n   = $signed({2'b00, r_segcnt});
        idx_raw = $signed({2'b00, r_trk_seg}) + IDX_W'(c_off);
        if (idx_raw < 0) begin
            cand_ld = -2'sd1;
            idx_adj = idx_raw + seg_n;
        end else if (idx_raw >= seg_n) begin
            cand_ld = 2'sd1;
            idx_adj = idx_raw - seg_n;
        end else begin
            cand_ld = 2'sd0;
            idx_adj = idx_raw;
        end
        cand_ok = ((cand_ld == 2'sd0) || r_closed) && (idx_adj >= 0) && (idx_adj < seg_n);
    end

    // Store read address.
    always_comb begin
        case (r_state)
            S_CAND:  rd_addr = AW'(idx_adj[SEG_W-1:0]);
            S_RDA:   rd_addr = AW'({1'b0, r_seg_cur} + (SEG_W+1)'(1));
            S_FIN:   rd_addr = AW'(r_best_seg);
            S_ARA:   rd_addr = AW'({1'b0, r_best_seg} + (SEG_W+1)'(1));
            default: rd_addr = '0;
        endcase
    end

    // Point store: written by loads, read one word a cycle.
    always_ff @(posedge i_clk) begin
        if (accept && (i_operation == OP_LOAD)) begin
            mem[AW'(i_entry_index)] <= {i_pos_x, i_pos_y, i_entry_arc};
        end
        r_rdata <= mem[rd_addr];
    end

    assign rd_x   = r_rdata[MEM_W-1 -: COORD_W];
    assign rd_y   = r_rdata[ARC_W +: COORD_W];
    assign rd_arc = r_rdata[ARC_W-1:0];

    // Operand selection for the shared multiplier.
    always_comb begin
        dx0   = $signed({r_px[COORD_W-1], r_px}) - $signed({r_ax[COORD_W-1], r_ax});
        dy0   = $signed({r_py[COORD_W-1], r_py}) - $signed({r_ay[COORD_W-1], r_ay});
        t_op  = (r_state == S_ARB) ? $signed(MB_W'(r_best_t)) : $signed(MB_W'(r_t));
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_MUL: begin
                case (r_step)
                    3'd0:    begin mul_a = MA_W'(r_abx); mul_b = MB_W'(r_abx); end
                    3'd1:    begin mul_a = MA_W'(r_aby); mul_b = MB_W'(r_aby); end
                    3'd2:    begin mul_a = MA_W'(dx0);   mul_b = MB_W'(r_abx); end
                    3'd3:    begin mul_a = MA_W'(dy0);   mul_b = MB_W'(r_aby); end
                    default: begin mul_a = '0;           mul_b = '0;           end
                endcase
            end
            S_PT: begin
                case (r_step)
                    3'd0:    begin mul_a = MA_W'(r_abx); mul_b = t_op;  end
                    3'd1:    begin mul_a = MA_W'(r_aby); mul_b = t_op;  end
                    3'd2:    begin mul_a = MA_W'(r_cx);  mul_b = r_cx;  end
                    3'd3:    begin mul_a = MA_W'(r_cy);  mul_b = r_cy;  end
                    default: begin mul_a = '0;           mul_b = '0;    end
                endcase
            end
            S_ARB: begin
                mul_a = MA_W'($signed({1'b0, rd_arc}) - $signed({1'b0, r_a0}));
                mul_b = t_op;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    // Rounded scale by the fraction, then the offset to the closest point.
    always_comb begin
        prod_rnd = (r_prod + PROD_W'(32768)) >>> FRAC_Q;
        near_off = PT_W'(prod_rnd);
        if (r_step == 3'd1) begin
            near_c = $signed({{2{r_px[COORD_W-1]}}, r_px})
                   - ($signed({{2{r_ax[COORD_W-1]}}, r_ax}) + near_off);
        end else begin
            near_c = $signed({{2{r_py[COORD_W-1]}}, r_py})
                   - ($signed({{2{r_ay[COORD_W-1]}}, r_ay}) + near_off);
        end
    end

    // Arc of the projection and the progress numerator.
    always_comb begin
        arc_sum  = $signed({2'b00, r_a0}) + (ARC_W+2)'(prod_rnd);
        case (r_best_ld)
            2'sd1:   ld_term = $signed({3'b000, r_total});
            -2'sd1:  ld_term = -$signed({3'b000, r_total});
            default: ld_term = '0;
        endcase
        num_calc = ld_term + $signed({3'b000, arc_sum[ARC_W-1:0]})
                 - $signed({3'b000, r_trk_arc});
        num_mag  = r_num[NUM_W-1] ? NUM_W'(-r_num) : NUM_W'(r_num);
        num_sat  = num_mag >= {1'b0, r_total, 2'b00};
    end

    // Divider requests: fraction of the dot product, or progress in laps.
    always_comb begin
        frc_div = (r_len2 != '0) && !r_dot[WIDE_W-1] && (r_dot != '0)
               && ($unsigned(r_dot) < r_len2);
        prg_div = (r_total != '0) && !num_sat;
        div_req.start = ((r_state == S_FRC) && frc_div) || ((r_state == S_PRG) && prg_div);
        if (r_state == S_PRG) begin
            div_req.steps = STEP_W'(QUOT_W);
            div_rem       = WIDE_W'(num_mag >> 2);
            div_div       = WIDE_W'(r_total);
            div_feed      = {num_mag[1:0], {(QUOT_W-2){1'b0}}};
        end else begin
            div_req.steps = STEP_W'(FRAC_Q);
            div_rem       = $unsigned(r_dot);
            div_div       = r_len2;
            div_feed      = '0;
        end
    end

    ppt_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .i_rem   (div_rem),
        .i_div   (div_div),
        .i_feed  (div_feed),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (accept && (i_operation == OP_PROJECT)) n_state = S_CAND;
            S_CAND: begin
                if (r_cand == CW'(CAND_N)) begin
                    n_state = S_FIN;
                end else if (cand_ok) begin
                    n_state = S_RDA;
                end
            end
            S_RDA:  n_state = S_RDB;
            S_RDB:  n_state = S_MUL;
            S_MUL:  if (r_step == 3'd4) n_state = S_FRC;
            S_FRC:  n_state = frc_div ? S_DIV : S_PT;
            S_DIV:  if (div_done) n_state = S_PT;
            S_PT:   if (r_step == 3'd4) n_state = S_CMP;
            S_CMP:  n_state = S_CAND;
            S_FIN:  n_state = r_found ? S_ARA : S_OUT;
            S_ARA:  n_state = S_ARB;
            S_ARB:  n_state = S_ARM;
            S_ARM:  n_state = S_PRG;
            S_PRG:  n_state = prg_div ? S_PDIV : S_OUT;
            S_PDIV: if (div_done) n_state = S_OUT;
            S_OUT:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Control, configuration and tracked state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_step     <= '0;
            r_cand     <= '0;
            r_done     <= 1'b0;
            r_found    <= 1'b0;
            r_closed   <= 1'b0;
            r_segcnt   <= SEG_W'(1);
            r_total    <= '0;
            r_trk_seg  <= '0;
            r_trk_frac <= '0;
            r_trk_lap  <= '0;
            r_trk_arc  <= '0;
        end else begin
            r_state <= n_state;
            r_done  <= 1'b0;

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_CLOSED: r_closed <= i_cfg_data[0];
                    CFG_SEGCNT: r_segcnt <= i_cfg_data[SEG_W-1:0];
                    CFG_TOTAL:  r_total  <= i_cfg_data[ARC_W-1:0];
                    default:    ;
                endcase
            end

            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_cand  <= '0;
                        r_found <= 1'b0;
                        if (i_operation == OP_RESTART) begin
                            r_trk_seg  <= '0;
                            r_trk_frac <= '0;
                            r_trk_lap  <= '0;
                            r_trk_arc  <= '0;
                        end
                        if (i_operation != OP_PROJECT) begin
                            r_done <= 1'b1;
                        end
                    end
                end
                S_CAND: if ((r_cand != CW'(CAND_N)) && !cand_ok) r_cand <= r_cand + CW'(1);
                S_RDB:  r_step <= '0;
                S_MUL:  r_step <= r_step + 3'd1;
                S_FRC:  r_step <= '0;
                S_DIV:  r_step <= '0;
                S_PT:   r_step <= r_step + 3'd1;
                S_CMP: begin
                    r_cand <= r_cand + CW'(1);
                    if (!r_found || (r_d2 < r_best_d2)) begin
                        r_found <= 1'b1;
                    end
                end
                S_OUT: begin
                    r_done <= 1'b1;
                    if (r_found) begin
                        r_trk_seg  <= r_best_seg;
                        r_trk_frac <= r_best_t;
                        r_trk_lap  <= r_trk_lap + LAP_W'(r_best_ld);
                        r_trk_arc  <= r_arc_new;
                    end
                end
                default: ;
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    r_px <= i_pos_x;
                    r_py <= i_pos_y;
                    // Loads, restarts and unused codes report the tracked state.
                    r_o_delta <= '0;
                    if (i_operation == OP_RESTART) begin
                        r_o_lap  <= '0;
                        r_o_seg  <= '0;
                        r_o_frac <= '0;
                        r_o_arc  <= '0;
                    end else begin
                        r_o_lap  <= r_trk_lap;
                        r_o_seg  <= r_trk_seg;
                        r_o_frac <= r_trk_frac;
                        r_o_arc  <= r_trk_arc;
                    end
                end
            end
            S_CAND: begin
                r_seg_cur <= idx_adj[SEG_W-1:0];
                r_ld_cur  <= cand_ld;
            end
            S_RDA: begin
                r_ax <= rd_x;
                r_ay <= rd_y;
            end
            S_RDB: begin
                r_abx <= $signed({rd_x[COORD_W-1], rd_x}) - $signed({r_ax[COORD_W-1], r_ax});
                r_aby <= $signed({rd_y[COORD_W-1], rd_y}) - $signed({r_ay[COORD_W-1], r_ay});
            end
            S_MUL: begin
                // Products are registered: each lands in the cycle after its operands.
                case (r_step)
                    3'd1:    r_len2 <= r_prod[WIDE_W-1:0];
                    3'd2:    r_len2 <= r_len2 + r_prod[WIDE_W-1:0];
                    3'd3:    r_dot  <= r_prod[WIDE_W-1:0];
                    3'd4:    r_dot  <= r_dot + r_prod[WIDE_W-1:0];
                    default: ;
                endcase
            end
            S_FRC: begin
                // A degenerate segment or a point at or behind its start clamps to zero, one at or past its end to one.
                if ((r_len2 == '0) || r_dot[WIDE_W-1] || (r_dot == '0)) begin
                    r_t <= '0;
                end else if (!frc_div) begin
                    r_t <= FRAC_ONE;
                end
            end
            S_DIV: if (div_done) r_t <= FRAC_W'(div_quot[FRAC_Q-1:0]);
            S_PT: begin
                case (r_step)
                    3'd1:    r_cx <= near_c;
                    3'd2:    r_cy <= near_c;
                    3'd3:    r_d2 <= r_prod[WIDE_W-1:0];
                    3'd4:    r_d2 <= r_d2 + r_prod[WIDE_W-1:0];
                    default: ;
                endcase
            end
            S_CMP: begin
                // The first strictly smaller distance wins.
                if (!r_found || (r_d2 < r_best_d2)) begin
                    r_best_d2  <= r_d2;
                    r_best_seg <= r_seg_cur;
                    r_best_t   <= r_t;
                    r_best_ld  <= r_ld_cur;
                end
            end
            S_FIN:  r_delta <= '0;
            S_ARA:  r_a0 <= rd_arc;
            S_ARM: begin
                r_arc_new <= arc_sum[ARC_W-1:0];
                r_num     <= num_calc;
            end
            S_PRG: begin
                if (r_total == '0) begin
                    r_delta <= '0;
                end else if (num_sat) begin
                    r_delta <= r_num[NUM_W-1] ? DELTA_MIN : DELTA_MAX;
                end
            end
            S_PDIV: begin
                if (div_done) begin
                    if (r_num[NUM_W-1]) begin
                        r_delta <= (div_quot > QUOT_W'(131072)) ? DELTA_MIN
                                                                : -$signed(div_quot);
                    end else begin
                        r_delta <= (div_quot > QUOT_W'(131071)) ? DELTA_MAX
                                                                : $signed(div_quot);
                    end
                end
            end
            S_OUT: begin
                r_o_delta <= r_found ? r_delta : '0;
                if (r_found) begin
                    r_o_lap  <= r_trk_lap + LAP_W'(r_best_ld);
                    r_o_seg  <= r_best_seg;
                    r_o_frac <= r_best_t;
                    r_o_arc  <= r_arc_new;
                end else begin
                    r_o_lap  <= r_trk_lap;
                    r_o_seg  <= r_trk_seg;
                    r_o_frac <= r_trk_frac;
                    r_o_arc  <= r_trk_arc;
                end
            end
            default: ;
        endcase
    end

    assign o_done             = r_done;
    assign o_progress_delta   = r_o_delta;
    assign o_lap_count        = r_o_lap;
    assign o_segment_now      = r_o_seg;
    assign o_segment_fraction = r_o_frac;
    assign o_arc_position     = r_o_arc;

    // The candidate counter never runs past the window.
    a_cand_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cand <= CW'(CAND_N))
        else $error("candidate counter beyond window");

    // The divider only finishes while the sequencer waits for it.
    a_div_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIV || r_state == S_PDIV))
        else $error("divider finished outside a wait state");

    // Every projection ends with a result word.
    a_proj_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_done)
        else $error("projection ended without a result");

endmodule

`default_nettype wire

FILE: hdl/ppt_divider.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle. Fresh dividend bits are
// shifted in from a feed word, most significant first.
module ppt_divider (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire ppt_pkg::t_div_req            i_req,
    input  wire logic [ppt_pkg::WIDE_W-1:0]   i_rem,
    input  wire logic [ppt_pkg::WIDE_W-1:0]   i_div,
    input  wire logic [ppt_pkg::QUOT_W-1:0]   i_feed,
    output logic                              o_done,
    output logic [ppt_pkg::QUOT_W-1:0]        o_quot
);
    import ppt_pkg::*;

    logic                r_busy;
    logic                r_done;
    logic [STEP_W-1:0]   r_cnt;
    logic [WIDE_W-1:0]   r_rem;
    logic [WIDE_W-1:0]   r_div;
    logic [QUOT_W-1:0]   r_feed;
    logic [QUOT_W-1:0]   r_quot;
    logic [WIDE_W:0]     shifted;
    logic [WIDE_W:0]     diff;
    logic                fits;

    // One trial subtraction per cycle.
    always_comb begin
        shifted = {r_rem, r_feed[QUOT_W-1]};
        diff    = shifted - {1'b0, r_div};
        fits    = shifted >= {1'b0, r_div};
    end

    // Control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == STEP_W'(1));
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - STEP_W'(1);
                if (r_cnt == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // Remainder and quotient.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem  <= i_rem;
            r_div  <= i_div;
            r_feed <= i_feed;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= fits ? diff[WIDE_W-1:0] : shifted[WIDE_W-1:0];
            r_feed <= {r_feed[QUOT_W-2:0], 1'b0};
            r_quot <= {r_quot[QUOT_W-2:0], fits};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

`default_nettype wire

FILE: dv/polyline_projection_tracker_unit_tb.sv
`default_nettype none

module polyline_projection_tracker_unit_tb;

    import ppt_pkg::*;

    localparam int N_PTS = DEF_MAX_POINTS;
    localparam int WIN   = DEF_WINDOW;

    // Expected result words, worked out from a private copy of the tracker state.
    class tracker_scoreboard;

        typedef struct {
            logic signed [DELTA_W-1:0] delta;
            logic [LAP_W-1:0]          lap;
            logic [SEG_W-1:0]          seg;
            logic [FRAC_W-1:0]         frac;
            logic [ARC_W-1:0]          arc;
        } word_t;

        logic signed [COORD_W-1:0] xs [N_PTS];
        logic signed [COORD_W-1:0] ys [N_PTS];
        logic [ARC_W-1:0]          arcs [N_PTS];
        logic [SEG_W-1:0]          trk_seg;
        logic [FRAC_W-1:0]         trk_frac;
        logic [LAP_W-1:0]          trk_lap;
        logic [ARC_W-1:0]          trk_arc;
        bit                        closed;
        logic [SEG_W-1:0]          nseg;
        logic [ARC_W-1:0]          tlen;
        word_t                     pending [$];
        int                        errors;

        function new();
            trk_seg  = '0;
            trk_frac = '0;
            trk_lap  = '0;
            trk_arc  = '0;
            closed   = 0;
            nseg     = 1;
            tlen     = '0;
            errors   = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
            case (idx)
                CFG_CLOSED: closed = d[0];
                CFG_SEGCNT: nseg = d[SEG_W-1:0];
                CFG_TOTAL:  tlen = d;
                default: ;
            endcase
        endfunction

        // Nearest point on one segment: clamped fraction and exact squared distance.
        function void nearest_on(int s, longint px, longint py,
                                 output longint unsigned d2, output logic [FRAC_W-1:0] t);
            int i0, i1;
            longint ax, ay, abx, aby, len2, dot, dx, dy;
            logic [67:0] wn, den, q;
            i0 = s % N_PTS;
            i1 = (s + 1) % N_PTS;
            ax = xs[i0];
            ay = ys[i0];
            abx = longint'(xs[i1]) - ax;
            aby = longint'(ys[i1]) - ay;
            len2 = abx * abx + aby * aby;
            dot = (px - ax) * abx + (py - ay) * aby;
            t = '0;
            if (len2 != 0 && dot > 0) begin
                if (dot >= len2) begin
                    t = FRAC_ONE;
                end else begin
                    wn = {dot[51:0], 16'h0};
                    den = 68'(len2);
                    q = wn / den;
                    t = q[FRAC_W-1:0];
                end
            end
            dx = px - (ax + ((abx * longint'(t) + 32768) >>> 16));
            dy = py - (ay + ((aby * longint'(t) + 32768) >>> 16));
            d2 = dx * dx + dy * dy;
        endfunction

        // Windowed search around the tracked segment, then arc and progress update.
        function void project(longint px, longint py, output longint delta);
            int n, c, off, idx, ld, best_seg, best_ld;
            bit found;
            longint unsigned d2, best_d2;
            logic [FRAC_W-1:0] t, best_t;
            longint a0, a1, arc, num, q;
            n = nseg;
            delta = 0;
            found = 0;
            best_d2 = 0;
            best_seg = 0;
            best_ld = 0;
            best_t = '0;
            if (n <= 0) return;
            for (c = 0; c <= 2 * WIN; c++) begin
                off = (c == 0) ? 0 : ((c % 2 == 1) ? (c + 1) / 2 : -(c / 2));
                idx = int'(trk_seg) + off;
                ld = 0;
                if (idx < 0) begin
                    if (!closed) continue;
                    ld = -1;
                    idx += n;
                end else if (idx >= n) begin
                    if (!closed) continue;
                    ld = 1;
                    idx -= n;
                end
                if (idx < 0 || idx >= n) continue;
                nearest_on(idx, px, py, d2, t);
                if (!found || d2 < best_d2) begin
                    found = 1;
                    best_d2 = d2;
                    best_seg = idx;
                    best_t = t;
                    best_ld = ld;
                end
            end
            if (!found) return;
            a0 = arcs[best_seg % N_PTS];
            a1 = arcs[(best_seg + 1) % N_PTS];
            arc = a0 + (((a1 - a0) * longint'(best_t) + 32768) >>> 16);
            num = longint'(best_ld) * longint'(tlen) + arc - longint'(trk_arc);
            if (tlen != 0) begin
                q = (num * 65536) / longint'(tlen);
                if (q > 131071) q = 131071;
                if (q < -131072) q = -131072;
                delta = q;
            end
            trk_lap  = trk_lap + LAP_W'(best_ld);
            trk_seg  = SEG_W'(best_seg);
            trk_frac = best_t;
            trk_arc  = arc[ARC_W-1:0];
        endfunction

        // Called for every accepted command word.
        function void note_input(logic [OP_W-1:0] op, logic [SEG_W-1:0] eidx,
                                 logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y,
                                 logic [ARC_W-1:0] earc);
            word_t w;
            longint delta;
            delta = 0;
            case (op)
                OP_LOAD: begin
                    xs[eidx % N_PTS] = x;
                    ys[eidx % N_PTS] = y;
                    arcs[eidx % N_PTS] = earc;
                end
                OP_PROJECT: project(longint'(x), longint'(y), delta);
                OP_RESTART: begin
                    trk_seg  = '0;
                    trk_frac = '0;
                    trk_lap  = '0;
                    trk_arc  = '0;
                end
                default: ;
            endcase
            w.delta = delta[DELTA_W-1:0];
            w.lap   = trk_lap;
            w.seg   = trk_seg;
            w.frac  = trk_frac;
            w.arc   = trk_arc;
            pending.push_back(w);
        endfunction

        // Called for every result word; compares with the oldest expectation.
        function void check_result(logic signed [DELTA_W-1:0] delta, logic [LAP_W-1:0] lap,
                                   logic [SEG_W-1:0] seg, logic [FRAC_W-1:0] frac,
                                   logic [ARC_W-1:0] arc);
            word_t w;
            if (pending.size() == 0) begin
                $error("result word with nothing expected");
                errors++;
                return;
            end
            w = pending.pop_front();
            if (delta !== w.delta) begin
                $error("progress_delta: expected %0d, got %0d", w.delta, delta);
                errors++;
            end
            if (lap !== w.lap) begin
                $error("lap_count: expected %0d, got %0d", w.lap, lap);
                errors++;
            end
            if (seg !== w.seg) begin
                $error("segment_now: expected %0d, got %0d", w.seg, seg);
                errors++;
            end
            if (frac !== w.frac) begin
                $error("segment_fraction: expected %0d, got %0d", w.frac, frac);
                errors++;
            end
            if (arc !== w.arc) begin
                $error("arc_position: expected %0d, got %0d", w.arc, arc);
                errors++;
            end
        endfunction

    endclass

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      start;
    logic                      busy;
    logic [OP_W-1:0]           i_operation;
    logic [SEG_W-1:0]          i_entry_index;
    logic signed [COORD_W-1:0] i_pos_x;
    logic signed [COORD_W-1:0] i_pos_y;
    logic [ARC_W-1:0]          i_entry_arc;
    logic                      i_cfg_we;
    logic [CFG_IDX_W-1:0]      i_cfg_idx;
    logic [CFG_DATA_W-1:0]     i_cfg_data;
    logic                      o_done;
    logic signed [DELTA_W-1:0] o_progress_delta;
    logic signed [LAP_W-1:0]   o_lap_count;
    logic [SEG_W-1:0]          o_segment_now;
    logic [FRAC_W-1:0]         o_segment_fraction;
    logic [ARC_W-1:0]          o_arc_position;

    tracker_scoreboard sb = new();

    // Path geometry as generated, kept to aim query points, reload path points and set the total length.
    longint path_x [N_PTS];
    longint path_y [N_PTS];
    longint path_arc [N_PTS];
    int     idle_pct;
    int     rand_done;

    polyline_projection_tracker_unit i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_operation        (i_operation),
        .i_entry_index      (i_entry_index),
        .i_pos_x            (i_pos_x),
        .i_pos_y            (i_pos_y),
        .i_entry_arc        (i_entry_arc),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_data         (i_cfg_data),
        .o_done             (o_done),
        .o_progress_delta   (o_progress_delta),
        .o_lap_count        (o_lap_count),
        .o_segment_now      (o_segment_now),
        .o_segment_fraction (o_segment_fraction),
        .o_arc_position     (o_arc_position)
    );

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Run limit.
    initial begin
        #20000000;
        $display("Some tests failed");
        $finish;
    end

    // Observe accepted command words and result words at the rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_done)
                sb.check_result(o_progress_delta, o_lap_count, o_segment_now,
                                o_segment_fraction, o_arc_position);
            if (start && !busy)
                sb.note_input(i_operation, i_entry_index, i_pos_x, i_pos_y, i_entry_arc);
        end
    end

    // Present one command word and hold it until accepted; returns at a falling edge.
    task automatic send(input logic [OP_W-1:0] op, input logic [SEG_W-1:0] eidx,
                        input logic signed [COORD_W-1:0] x, input logic signed [COORD_W-1:0] y,
                        input logic [ARC_W-1:0] earc);
        if ($urandom_range(99) < idle_pct) begin
            start = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        i_operation   = op;
        i_entry_index = eidx;
        i_pos_x       = x;
        i_pos_y       = y;
        i_entry_arc   = earc;
        start         = 1'b1;
        do @(posedge i_clk); while (busy !== 1'b0);
        @(negedge i_clk);
    endtask

    // Wait until every expected word has come back.
    task automatic settle();
        start = 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = d;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
        sb.set_reg(idx, d);
    endtask

    // Random walk of n segments, loaded point by point; a closed path ends where it began.
    task automatic load_path(input int n, input bit closed);
        int i;
        longint dx, dy;
        path_x[0] = $urandom_range(0, 200000) - 100000;
        path_y[0] = $urandom_range(0, 200000) - 100000;
        path_arc[0] = 0;
        for (i = 1; i <= n; i++) begin
            dx = longint'($urandom_range(0, 2000)) - 1000;
            dy = longint'($urandom_range(0, 2000)) - 1000;
            if (closed && i == n) begin
                dx = path_x[0] - path_x[i-1];
                dy = path_y[0] - path_y[i-1];
            end
            path_x[i] = path_x[i-1] + dx;
            path_y[i] = path_y[i-1] + dy;
            path_arc[i] = path_arc[i-1] + (dx < 0 ? -dx : dx) + (dy < 0 ? -dy : dy);
        end
        for (i = 0; i <= n; i++)
            send(OP_LOAD, SEG_W'(i), COORD_W'(path_x[i]), COORD_W'(path_y[i]),
                 ARC_W'(path_arc[i]));
    endtask

    // A query point near the path, mostly within three segments of the tracked one.
    task automatic send_query(input int n);
        int s, f;
        longint qx, qy;
        s = int'(sb.trk_seg) + $urandom_range(0, 6) - 3;
        if ($urandom_range(9) == 0) s = $urandom_range(0, n - 1);
        s = ((s % n) + n) % n;
        f = $urandom_range(0, 300) - 22;
        qx = path_x[s] + ((path_x[s+1] - path_x[s]) * f) / 256 + $urandom_range(0, 400) - 200;
        qy = path_y[s] + ((path_y[s+1] - path_y[s]) * f) / 256 + $urandom_range(0, 400) - 200;
        send(OP_PROJECT, SEG_W'($urandom()), COORD_W'(qx), COORD_W'(qy), ARC_W'($urandom()));
    endtask

    // One random command word: mostly tracking queries, with loads, restarts and noise.
    task automatic rand_item(input int n);
        int r, i;
        r = $urandom_range(99);
        if (r < 62) begin
            send_query(n);
        end else if (r < 70) begin
            send(OP_PROJECT, SEG_W'($urandom()), COORD_W'($urandom()), COORD_W'($urandom()),
                 ARC_W'($urandom()));
        end else if (r < 82) begin
            send(OP_LOAD, SEG_W'($urandom()), COORD_W'($urandom()), COORD_W'($urandom()),
                 ARC_W'($urandom()));
        end else if (r < 90) begin
            i = $urandom_range(0, n);
            send(OP_LOAD, SEG_W'(i), COORD_W'(path_x[i]), COORD_W'(path_y[i]),
                 ARC_W'(path_arc[i]));
        end else if (r < 96) begin
            send(OP_RESTART, SEG_W'($urandom()), COORD_W'($urandom()), COORD_W'($urandom()),
                 ARC_W'($urandom()));
        end else begin
            send(2'd3, SEG_W'($urandom()), COORD_W'($urandom()), COORD_W'($urandom()),
                 ARC_W'($urandom()));
        end
    endtask

    // One setting of the registers: new path, restart, then random words.
    // Length mode: 0 path length, 1 zero, 2 largest, 3 one (saturates progress).
    task automatic run_phase(input bit closed, input int n, input int len_mode, input int count);
        int k;
        logic [ARC_W-1:0] tl;
        settle();
        write_reg(CFG_CLOSED, CFG_DATA_W'(closed));
        write_reg(CFG_SEGCNT, CFG_DATA_W'(n));
        load_path(n, closed);
        case (len_mode)
            0: tl = ARC_W'(path_arc[n]);
            1: tl = '0;
            2: tl = '1;
            default: tl = 32'd1;
        endcase
        settle();
        write_reg(CFG_TOTAL, tl);
        send(OP_RESTART, '0, '0, '0, '0);
        for (k = 0; k < count; k++) begin
            idle_pct = (rand_done < 470) ? 32 : ((rand_done < 940) ? 88 : 0);
            rand_item(n);
            rand_done++;
        end
    endtask

    initial begin
        start         = 1'b0;
        i_operation   = OP_LOAD;
        i_entry_index = '0;
        i_pos_x       = '0;
        i_pos_y       = '0;
        i_entry_arc   = '0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = CFG_CLOSED;
        i_cfg_data    = '0;
        idle_pct      = 0;
        rand_done     = 0;
        i_rst_n       = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed: unused code and restart on fresh state, corner points, degenerate segment.
        send(2'd3, '1, '1, '1, '1);
        send(OP_RESTART, '0, '0, '0, '0);
        send(OP_LOAD, 12'd0, 24'sh800000, 24'sh800000, 32'd0);
        send(OP_LOAD, 12'd1, 24'sh7FFFFF, 24'sh7FFFFF, 32'hFFFF_FFFF);
        send(OP_LOAD, 12'hFFF, 24'sh7FFFFF, 24'sh800000, 32'hFFFF_FFFF);
        send(OP_PROJECT, '0, 24'sh7FFFFF, 24'sh7FFFFF, '0);
        send(OP_PROJECT, '0, 24'sh800000, 24'sh800000, '0);
        send(OP_PROJECT, '0, 24'sh800000, 24'sh7FFFFF, '0);
        send(OP_PROJECT, '0, 24'sh000100, 24'sh000080, '1);
        send(OP_LOAD, 12'd1, 24'sh800000, 24'sh800000, 32'd0);
        send(OP_PROJECT, '0, 24'sh123456, 24'sh7FFFFF, '0);
        send(OP_LOAD, 12'd1, 24'sh000000, 24'sh000000, 32'd1000);
        send(OP_PROJECT, '0, 24'sh000000, 24'sh000000, '0);
        send(OP_RESTART, '1, '1, '1, '1);
        send(2'd3, '0, '0, '0, '0);

        // Register settings, extremes among them.
        run_phase(1'b1, 3, 0, 150);
        run_phase(1'b0, 40, 0, 250);
        run_phase(1'b1, 40, 3, 150);
        run_phase(1'b1, 1, 2, 100);
        run_phase(1'b1, 4095, 0, 120);
        run_phase(1'b0, 4095, 1, 80);
        run_phase(1'b1, 24, 0, 300);
        run_phase(1'b0, 12, 2, 250);

        settle();
        repeat (20) @(negedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

FILE: files.f
hdl/ppt_pkg.sv
hdl/ppt_divider.sv
hdl/polyline_projection_tracker_unit.sv
dv/polyline_projection_tracker_unit_tb.sv
